### rtl/sar_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package sar_pkg;
  localparam int TableEntries = 16;
  localparam int IdxW = (TableEntries > 1) ? $clog2(TableEntries) : 1;
  localparam logic [15:0] SegMin = 16'd1024;
  localparam logic [15:0] SegReset = 16'd1500;
  localparam logic [16:0] RecvMax = 17'h1FFFF;
  localparam int QueueDepth = 2;

  typedef enum logic [1:0] {
    ModeSplit = 2'd0,
    ModeReasmSplit = 2'd1,
    ModeReasmWhole = 2'd2,
    ModePass = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    StOk = 2'd0,
    StZeroLen = 2'd1,
    StFull = 2'd2
  } status_e;

  // One job for the back end: either cut total into segments or emit it once.
  typedef struct packed {
    logic [15:0] job;
    logic [7:0] task_id;
    logic [15:0] total;
    logic cut;
    logic [1:0] status;
  } job_t;
endpackage
`default_nettype wire

### rtl/sar_front.sv
`timescale 1ns / 1ps
`default_nettype none
module sar_front import sar_pkg::*; (
  input wire logic clk_i,
  input wire logic rst_ni,
  input wire logic in_valid_i,
  output logic in_stall_o,
  input wire logic [1:0] mode_i,
  input wire logic [15:0] job_id_i,
  input wire logic [7:0] task_id_i,
  input wire logic [15:0] frag_bytes_i,
  input wire logic [15:0] expected_bytes_i,
  output logic job_valid_o,
  output job_t job_o,
  input wire logic job_ready_i
);
  logic [TableEntries-1:0] vld_q, vld_d;
  logic [15:0] tjob_q [TableEntries];
  logic [7:0] ttask_q [TableEntries];
  logic [15:0] texp_q [TableEntries];
  logic [16:0] trcv_q [TableEntries];

  // Input register: one word classified per cycle once it sits here, unless the queue is full and it stalls.
  logic hold_q;
  logic [1:0] mode_q;
  logic [15:0] job_q, frag_q, exp_q;
  logic [7:0] task_q;

  logic hit, freef;
  logic [IdxW-1:0] hit_idx, free_idx, sel;
  logic [17:0] sum;
  logic [16:0] newrcv;
  logic emit, upd, fire;
  job_t jb;

  always_comb begin
    hit = 1'b0;
    freef = 1'b0;
    hit_idx = '0;
    free_idx = '0;
    for (int i = TableEntries - 1; i >= 0; i--) begin
      if (vld_q[i] && tjob_q[i] == job_q && ttask_q[i] == task_q) begin
        hit = 1'b1;
        hit_idx = IdxW'(i);
      end
      if (!vld_q[i]) begin
        freef = 1'b1;
        free_idx = IdxW'(i);
      end
    end
    sel = hit ? hit_idx : free_idx;
    sum = {1'b0, trcv_q[hit_idx]} + {2'b0, frag_q};
    newrcv = hit ? ((sum > {1'b0, RecvMax}) ? RecvMax : sum[16:0]) : {1'b0, frag_q};

    jb.job = job_q;
    jb.task_id = task_q;
    jb.total = frag_q;
    jb.cut = 1'b0;
    jb.status = StOk;
    emit = 1'b1;
    upd = 1'b0;
    if (frag_q == '0) begin
      jb.status = StZeroLen;
    end else if (mode_q == ModeSplit) begin
      jb.cut = 1'b1;
    end else if (mode_q == ModePass) begin
    end else if (!hit && !freef) begin
      jb.total = '0;
      jb.status = StFull;
    end else begin
      upd = 1'b1;
      jb.total = hit ? texp_q[hit_idx] : exp_q;
      emit = (newrcv == {1'b0, jb.total});
      jb.cut = (mode_q == ModeReasmSplit);
    end
    fire = hold_q && (!emit || job_ready_i);
    vld_d = vld_q;
    if (fire && upd) vld_d[sel] = !emit;
  end

  assign job_valid_o = hold_q && emit;
  assign job_o = jb;
  assign in_stall_o = hold_q && !fire;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_q <= 1'b0;
      vld_q <= '0;
    end else begin
      vld_q <= vld_d;
      if (fire) hold_q <= 1'b0;
      if (in_valid_i && !in_stall_o) hold_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      mode_q <= mode_i;
      job_q <= job_id_i;
      task_q <= task_id_i;
      frag_q <= frag_bytes_i;
      exp_q <= expected_bytes_i;
    end
    if (fire && upd) begin
      tjob_q[sel] <= job_q;
      ttask_q[sel] <= task_q;
      texp_q[sel] <= jb.total;
      trcv_q[sel] <= newrcv;
    end
  end
endmodule
`default_nettype wire

### rtl/sar_queue.sv
`timescale 1ns / 1ps
`default_nettype none
module sar_queue import sar_pkg::*; (
  input wire logic clk_i,
  input wire logic rst_ni,
  input wire logic wr_valid_i,
  output logic wr_ready_o,
  input wire job_t wr_data_i,
  output logic rd_valid_o,
  output job_t rd_data_o,
  input wire logic rd_ready_i
);
  localparam int PtrW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  job_t mem_q [QueueDepth];
  logic [PtrW-1:0] wp_q, rp_q;
  logic [PtrW:0] cnt_q;
  logic wr, rd;

  assign wr_ready_o = cnt_q != (PtrW+1)'(QueueDepth);
  assign rd_valid_o = cnt_q != '0;
  assign rd_data_o = mem_q[rp_q];
  assign wr = wr_valid_i && wr_ready_o;
  assign rd = rd_valid_o && rd_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= '0;
      rp_q <= '0;
      cnt_q <= '0;
    end else begin
      if (wr) wp_q <= (wp_q == PtrW'(QueueDepth - 1)) ? '0 : wp_q + 1'b1;
      if (rd) rp_q <= (rp_q == PtrW'(QueueDepth - 1)) ? '0 : rp_q + 1'b1;
      cnt_q <= cnt_q + (PtrW+1)'(wr) - (PtrW+1)'(rd);
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr) mem_q[wp_q] <= wr_data_i;
  end
endmodule
`default_nettype wire

### rtl/sar_back.sv
`timescale 1ns / 1ps
`default_nettype none
module sar_back import sar_pkg::*; (
  input wire logic clk_i,
  input wire logic rst_ni,
  input wire logic [15:0] seg_size_i,
  input wire logic job_valid_i,
  input wire job_t job_i,
  output logic job_ready_o,
  output logic out_valid_o,
  input wire logic out_stall_i,
  output logic [15:0] out_job_id_o,
  output logic [7:0] out_task_id_o,
  output logic [15:0] seg_bytes_o,
  output logic last_o,
  output logic [1:0] status_o
);
  logic busy_q, ov_q;
  job_t cur_q;
  logic [15:0] seg;
  logic free;

  assign seg = (seg_size_i < SegMin) ? SegMin : seg_size_i;
  // The output register frees when empty or taken this cycle.
  assign free = !ov_q || !out_stall_i;
  assign job_ready_o = !busy_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      ov_q <= 1'b0;
    end else begin
      if (free) ov_q <= busy_q;
      if (!busy_q && job_valid_i) busy_q <= 1'b1;
      else if (busy_q && free && !(cur_q.cut && cur_q.total > seg)) busy_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!busy_q && job_valid_i) cur_q <= job_i;
    if (busy_q && free) begin
      out_job_id_o <= cur_q.job;
      out_task_id_o <= cur_q.task_id;
      status_o <= cur_q.status;
      if (cur_q.cut && cur_q.total > seg) begin
        seg_bytes_o <= seg;
        last_o <= 1'b0;
        cur_q.total <= cur_q.total - seg;
      end else begin
        seg_bytes_o <= cur_q.total;
        last_o <= 1'b1;
      end
    end
  end

  assign out_valid_o = ov_q;
endmodule
`default_nettype wire

### rtl/segment_and_reassemble.sv
`timescale 1ns / 1ps
`default_nettype none
// Segmentation and reassembly. A fragment word is classified in the
// front end (table lookup over the 16-entry reassembly table) and then
// the back end emits one result word per cycle while out_stall_i is low:
// a cut gives ceil(length / max(segment_size, 1024)) words, all other
// cases one word or none. The back end takes a new job only once its
// current one is done. The table resets to empty at once.
module segment_and_reassemble import sar_pkg::*; (
  input wire logic clk_i,
  input wire logic rst_ni,
  input wire logic cfg_valid_i,
  output logic cfg_ready_o,
  input wire logic [15:0] cfg_data_i,
  input wire logic in_valid_i,
  output logic in_stall_o,
  input wire logic [1:0] mode_i,
  input wire logic [15:0] job_id_i,
  input wire logic [7:0] task_id_i,
  input wire logic [15:0] frag_bytes_i,
  input wire logic [15:0] expected_bytes_i,
  output logic out_valid_o,
  input wire logic out_stall_i,
  output logic [15:0] out_job_id_o,
  output logic [7:0] out_task_id_o,
  output logic [15:0] seg_bytes_o,
  output logic last_o,
  output logic [1:0] status_o
);
  logic [15:0] seg_q;
  logic fv, fr, bv, br;
  job_t fj, bj;

  assign cfg_ready_o = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) seg_q <= SegReset;
    else if (cfg_valid_i) seg_q <= cfg_data_i;
  end

  sar_front u_front (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .mode_i, .job_id_i, .task_id_i,
    .frag_bytes_i, .expected_bytes_i,
    .job_valid_o(fv), .job_o(fj), .job_ready_i(fr)
  );

  sar_queue u_queue (
    .clk_i, .rst_ni, .wr_valid_i(fv), .wr_ready_o(fr), .wr_data_i(fj),
    .rd_valid_o(bv), .rd_data_o(bj), .rd_ready_i(br)
  );

  sar_back u_back (
    .clk_i, .rst_ni, .seg_size_i(seg_q), .job_valid_i(bv), .job_i(bj),
    .job_ready_o(br), .out_valid_o, .out_stall_i, .out_job_id_o,
    .out_task_id_o, .seg_bytes_o, .last_o, .status_o
  );
endmodule
`default_nettype wire

### verif/tb.sv
`timescale 1ns / 1ps
module tb;
  import sar_pkg::*;

  typedef struct packed {
    logic [15:0] job;
    logic [7:0] task_id;
    logic [15:0] bytes;
    logic last;
    logic [1:0] status;
  } seg_t;

  typedef struct {
    bit valid;
    logic [15:0] job;
    logic [7:0] task_id;
    logic [15:0] expected;
    logic [16:0] received;
  } entry_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [15:0] cfg_data_i = '0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic [1:0] mode_i = '0;
  logic [15:0] job_id_i = '0;
  logic [7:0] task_id_i = '0;
  logic [15:0] frag_bytes_i = '0;
  logic [15:0] expected_bytes_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic [15:0] out_job_id_o;
  logic [7:0] out_task_id_o;
  logic [15:0] seg_bytes_o;
  logic last_o;
  logic [1:0] status_o;

  segment_and_reassemble i_dut (.*);

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  entry_t table_q[TableEntries];
  logic [15:0] seg_size_q;
  seg_t expected_segs[$];
  int mismatches = 0;
  bit idle_on = 1'b1;
  bit hold_rx = 1'b0;
  int max_gap = 8;
  int rx_idle = 0;

  task automatic add_cuts(logic [15:0] job, logic [7:0] tid, int total);
    int seg;
    seg = (seg_size_q < SegMin) ? int'(SegMin) : int'(seg_size_q);
    while (total > seg) begin
      expected_segs.push_back('{job, tid, 16'(seg), 1'b0, StOk});
      total -= seg;
    end
    expected_segs.push_back('{job, tid, 16'(total), 1'b1, StOk});
  endtask

  task automatic predict_fragment(logic [1:0] md, logic [15:0] job, logic [7:0] tid,
                                  logic [15:0] frag, logic [15:0] exp_b);
    int hit, free_slot, total;
    hit = -1;
    free_slot = -1;
    if (frag == 0) begin
      expected_segs.push_back('{job, tid, 16'd0, 1'b1, StZeroLen});
      return;
    end
    if (md == ModeSplit) begin
      add_cuts(job, tid, frag);
      return;
    end
    if (md == ModePass) begin
      expected_segs.push_back('{job, tid, frag, 1'b1, StOk});
      return;
    end
    for (int i = 0; i < TableEntries; i++) begin
      if (table_q[i].valid) begin
        if (hit < 0 && table_q[i].job == job && table_q[i].task_id == tid) hit = i;
      end else if (free_slot < 0) begin
        free_slot = i;
      end
    end
    if (hit >= 0) begin
      if (int'(table_q[hit].received) + frag > int'(RecvMax)) table_q[hit].received = RecvMax;
      else table_q[hit].received = table_q[hit].received + frag;
    end else if (free_slot >= 0) begin
      hit = free_slot;
      table_q[hit] = '{1'b1, job, tid, exp_b, {1'b0, frag}};
    end else begin
      expected_segs.push_back('{job, tid, 16'd0, 1'b1, StFull});
      return;
    end
    if (table_q[hit].received != {1'b0, table_q[hit].expected}) return;
    total = table_q[hit].expected;
    table_q[hit] = '{1'b0, '0, '0, '0, '0};
    if (md == ModeReasmSplit) add_cuts(job, tid, total);
    else expected_segs.push_back('{job, tid, 16'(total), 1'b1, StOk});
  endtask

  task automatic send_fragment(logic [1:0] md, logic [15:0] job, logic [7:0] tid,
                               logic [15:0] frag, logic [15:0] exp_b);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, max_gap)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    mode_i <= md;
    job_id_i <= job;
    task_id_i <= tid;
    frag_bytes_i <= frag;
    expected_bytes_i <= exp_b;
    predict_fragment(md, job, tid, frag, exp_b);
    do @(posedge clk_i); while (in_stall_o);
  endtask

  task automatic end_burst();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic drain();
    int guard;
    guard = 0;
    while (expected_segs.size() != 0 && guard < 200000) begin
      @(posedge clk_i);
      guard++;
    end
    repeat (80) @(posedge clk_i);
  endtask

  task automatic write_seg_size(logic [15:0] val);
    drain();
    cfg_valid_i <= 1'b1;
    cfg_data_i <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    seg_size_q = val;
    @(posedge clk_i);
  endtask

  // The receiver side: random stall bursts, plus a long hold when requested.
  always @(posedge clk_i) begin
    if (hold_rx) out_stall_i <= 1'b1;
    else if (idle_on && rx_idle > 0) begin
      out_stall_i <= 1'b1;
      rx_idle <= rx_idle - 1;
    end else if (idle_on && $urandom_range(0, 4) == 0) begin
      out_stall_i <= 1'b1;
      rx_idle <= int'($urandom_range(0, 7));
    end else out_stall_i <= 1'b0;
  end

  always @(posedge clk_i) begin
    seg_t got, want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      got = '{out_job_id_o, out_task_id_o, seg_bytes_o, last_o, status_o};
      if (expected_segs.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected word: %p", got);
      end else begin
        want = expected_segs.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10) $display("mismatch: expected %p actual %p", want, got);
        end
      end
    end
  end

  task automatic test_extremes();
    send_fragment(ModeSplit, 16'hFFFF, 8'hFF, 16'hFFFF, 16'hFFFF);
    send_fragment(ModeSplit, 16'h0000, 8'h00, 16'd1, 16'd0);
    send_fragment(ModeSplit, 16'h1234, 8'h5A, 16'd1500, 16'd0);
    send_fragment(ModeSplit, 16'h1234, 8'h5A, 16'd1501, 16'd0);
    send_fragment(ModePass, 16'hA5A5, 8'hC3, 16'hFFFF, 16'h0);
    for (int m = 0; m < 4; m++) send_fragment(m[1:0], 16'h0042, 8'h07, 16'd0, 16'd100);
    end_burst();
  endtask

  task automatic test_reassembly();
    send_fragment(ModeReasmSplit, 16'd10, 8'd1, 16'd3000, 16'd5000);
    send_fragment(ModeReasmWhole, 16'd10, 8'd1, 16'd2000, 16'd1);
    send_fragment(ModeReasmWhole, 16'd11, 8'd2, 16'd700, 16'd700);
    send_fragment(ModeReasmWhole, 16'd12, 8'd2, 16'd1, 16'd0);
    send_fragment(ModeReasmSplit, 16'd13, 8'd3, 16'hFFFF, 16'hFFFF);
    send_fragment(ModeReasmSplit, 16'd14, 8'd3, 16'hFFFF, 16'd9);
    send_fragment(ModeReasmSplit, 16'd14, 8'd3, 16'hFFFF, 16'd9);
    send_fragment(ModeReasmSplit, 16'd14, 8'd3, 16'hFFFF, 16'd9);
    end_burst();
  endtask

  task automatic test_table_full();
    for (int i = 0; i < TableEntries + 2; i++)
      send_fragment(ModeReasmWhole, 16'(16'h100 + i), 8'(i), 16'd5, 16'd9);
    end_burst();
  endtask

  task automatic test_segment_sizes();
    write_seg_size(16'd0);
    send_fragment(ModeSplit, 16'd1, 8'd1, 16'hFFFF, 16'd0);
    end_burst();
    write_seg_size(16'hFFFF);
    send_fragment(ModeSplit, 16'd2, 8'd2, 16'hFFFF, 16'd0);
    end_burst();
    write_seg_size(16'd1024);
    send_fragment(ModeSplit, 16'd3, 8'd3, 16'd4097, 16'd0);
    end_burst();
  endtask

  // Keeps the receiver stalled so the block fills up and stalls its input.
  task automatic test_backpressure();
    fork
      begin
        int cycles;
        cycles = 0;
        hold_rx = 1'b1;
        while (cycles < 300) begin
          @(posedge clk_i);
          cycles++;
        end
        hold_rx = 1'b0;
      end
      for (int i = 0; i < 12; i++)
        send_fragment(ModeSplit, 16'($urandom), 8'($urandom), 16'($urandom_range(1, 5000)), 16'd0);
    join
    end_burst();
  endtask

  // -1 when the table already holds an entry for the job and task, else 0.
  function automatic int table_sum(logic [15:0] job, logic [7:0] tid);
    for (int i = 0; i < TableEntries; i++)
      if (table_q[i].valid && table_q[i].job == job && table_q[i].task_id == tid) return -1;
    return 0;
  endfunction

  task automatic test_random(int count);
    logic [1:0] md;
    logic [15:0] job, frag, tot;
    logic [7:0] tid;
    int parts;
    for (int n = 0; n < count; n++) begin
      idle_on = (n < count - 40);
      md = 2'($urandom);
      job = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 20));
      tid = ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(0, 3));
      if ((md == ModeReasmSplit || md == ModeReasmWhole) && $urandom_range(0, 4) != 0) begin
        // Well-formed reassembly: fragments summing exactly to the total.
        tot = ($urandom_range(0, 7) == 0) ? 16'($urandom) : 16'($urandom_range(2, 6000));
        if (tot < 2) tot = 2;
        parts = $urandom_range(1, 3);
        while (tot != 0) begin
          frag = (parts == 1) ? tot : 16'($urandom_range(1, tot));
          tot = tot - frag;
          parts--;
          send_fragment(md, job, tid, frag, frag + tot + 16'(table_sum(job, tid)));
          if (parts == 0 && tot != 0) parts = 1;
        end
        n += 2;
      end else begin
        frag = ($urandom_range(0, 9) == 0) ? 16'd0 :
               ($urandom_range(0, 5) == 0) ? 16'($urandom) : 16'($urandom_range(1, 6000));
        send_fragment(md, job, tid, frag, 16'($urandom));
      end
    end
    end_burst();
  endtask

  initial begin
    for (int i = 0; i < TableEntries; i++) table_q[i] = '{1'b0, '0, '0, '0, '0};
    seg_size_q = SegReset;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_extremes();
    test_reassembly();
    test_table_full();
    test_segment_sizes();
    write_seg_size(16'd1500);
    test_backpressure();
    write_seg_size(16'($urandom_range(1024, 3000)));
    test_random(100);
    write_seg_size(16'($urandom_range(0, 1023)));
    test_random(110);
    drain();
    if (mismatches == 0 && expected_segs.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("CHECKS FAILED");
    $finish;
  end
endmodule

### sim.f
rtl/sar_pkg.sv
rtl/sar_front.sv
rtl/sar_queue.sv
rtl/sar_back.sv
rtl/segment_and_reassemble.sv
verif/tb.sv
